FILE: sv/cmtc_pkg.sv
// ----------------------------------------------------------------------------
// cmtc_pkg
// Shared types and constants for the three-C miss classifier: beat
// widths of the stream ports and the miss kind codes.
// ----------------------------------------------------------------------------
package cmtc_pkg;

  // input beat: line_addr, real_miss, fills_line packed from bit 0
  localparam int ADDR_IN_W = 16;
  localparam int IN_DATA_W = 24;

  // result beat: is_classified, miss_kind packed from bit 0
  localparam int OUT_DATA_W = 8;

  // shadow_lines register
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] SHADOW_LINES_RST = 7'd64;

  // miss kinds
  typedef enum logic [1:0] {
    KIND_COLD     = 2'd0,
    KIND_POLICY   = 2'd1,
    KIND_CONFLICT = 2'd2,
    KIND_CAPACITY = 2'd3
  } kind_t;

endpackage

FILE: sv/cache_miss_three_c_classifier.sv
// ----------------------------------------------------------------------------
// cache_miss_three_c_classifier
// Classifies each real cache miss as cold, policy, conflict or capacity
// using a seen bitmap in RAM and a fully associative LRU shadow cache.
// ----------------------------------------------------------------------------
// Path: accepted input beat, stage 1 register, output register, out_tvalid.
// Throughput: one access per cycle unless the output stalls; tag compare and
//   LRU age update finish in the accept cycle, the seen bit is read and marked
//   then and used when stage 1 advances. Reset: the seen bitmap is cleared by
//   a pass over all 2**LINE_BITS addresses (65536 at the default) with
//   in_tready low; shadow_lines returns to 64 and the shadow cache is empty.
module cache_miss_three_c_classifier #(
  parameter int MAX_SHADOW_LINES = 64,
  parameter int LINE_BITS        = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: line_addr[15:0], real_miss[16], fills_line[17], zero pad
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cmtc_pkg::IN_DATA_W-1:0]   in_tdata,
  // out_tdata: is_classified[0], miss_kind[2:1], zero pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cmtc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [cmtc_pkg::CFG_W-1:0]       cfg_wr_data
);

  import cmtc_pkg::*;

  localparam int CNT_W = $clog2(MAX_SHADOW_LINES + 1);
  localparam int AGE_W = (MAX_SHADOW_LINES > 1) ? $clog2(MAX_SHADOW_LINES) : 1;
  localparam int SEEN_DEPTH = 1 << LINE_BITS;

  // ---------------------------------------------------------------------------
  // input beat fields
  logic [LINE_BITS-1:0] line;
  logic                 real_miss;
  logic                 fills_line;
  logic                 in_acc;

  assign line       = LINE_BITS'(in_tdata[ADDR_IN_W-1:0]);
  assign real_miss  = in_tdata[ADDR_IN_W];
  assign fills_line = in_tdata[ADDR_IN_W+1];
  assign in_acc     = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // seen bitmap clearing pass after reset
  logic                 clr_active_r;
  logic [LINE_BITS-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // seen bitmap: read old bit and mark it in the accept cycle
  logic                 seen_we;
  logic                 seen_wdata;
  logic [LINE_BITS-1:0] seen_addr;
  logic                 seen_rdata;

  assign seen_we    = clr_active_r || in_acc;
  assign seen_wdata = !clr_active_r;
  assign seen_addr  = clr_active_r ? clr_addr_r : line;

  cmtc_ram #(
    .WIDTH (1),
    .DEPTH (SEEN_DEPTH)
  ) u_seen_ram (
    .clk   (clk),
    .en    (in_acc),
    .we    (seen_we),
    .addr  (seen_addr),
    .wdata (seen_wdata),
    .rdata (seen_rdata)
  );

  // ---------------------------------------------------------------------------
  // configuration register
  logic [CFG_W-1:0] shadow_lines_r;
  logic [CNT_W-1:0] cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_lines_r <= SHADOW_LINES_RST;
    end else if (cfg_wr_en) begin
      shadow_lines_r <= cfg_wr_data;
    end
  end

  // saturate to the shadow cache size
  assign cap = (32'(shadow_lines_r) > 32'(MAX_SHADOW_LINES)) ?
               CNT_W'(MAX_SHADOW_LINES) : CNT_W'(shadow_lines_r);

  // ---------------------------------------------------------------------------
  // shadow cache: tag compare and LRU age update in the accept cycle
  logic [LINE_BITS-1:0]        tag_r [MAX_SHADOW_LINES];
  logic [AGE_W-1:0]            age_r [MAX_SHADOW_LINES];
  logic [CNT_W-1:0]            fill_count_r;
  logic [CNT_W-1:0]            fill_count_nxt;
  logic [MAX_SHADOW_LINES-1:0] valid;
  logic [MAX_SHADOW_LINES-1:0] hit_vec;
  logic [MAX_SHADOW_LINES-1:0] repl_vec;
  logic [MAX_SHADOW_LINES-1:0] inc_vec;
  logic [AGE_W-1:0]            hit_age;
  logic [CNT_W-1:0]            old_age;
  logic                        shadow_hit;
  logic                        shadow_full;
  logic                        touch;

  assign touch       = in_acc && fills_line;
  assign shadow_full = (fill_count_r == cap);

  always_comb begin
    hit_age = '0;
    for (int i = 0; i < MAX_SHADOW_LINES; i++) begin
      valid[i]   = CNT_W'(i) < fill_count_r;
      hit_vec[i] = valid[i] && (tag_r[i] == line);
      if (hit_vec[i]) begin
        hit_age = hit_age | age_r[i];
      end
    end
  end

  assign shadow_hit = |hit_vec;
  // a hit promotes its own age; a fill or a replacement ages everything
  assign old_age = shadow_hit ? CNT_W'(hit_age) : fill_count_r;

  always_comb begin
    for (int i = 0; i < MAX_SHADOW_LINES; i++) begin
      if (shadow_hit) begin
        repl_vec[i] = hit_vec[i];
      end else if (shadow_full) begin
        repl_vec[i] = valid[i] && (CNT_W'(age_r[i]) == cap - 1'b1);
      end else begin
        repl_vec[i] = (CNT_W'(i) == fill_count_r);
      end
      inc_vec[i] = valid[i] && (CNT_W'(age_r[i]) < old_age);
    end
  end

  // fill count: emptied by a register write, grows on a non-full miss
  always_comb begin
    fill_count_nxt = fill_count_r;
    if (cfg_wr_en) begin
      fill_count_nxt = '0;
    end else if (touch && !shadow_hit && !shadow_full) begin
      fill_count_nxt = fill_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
    end else begin
      fill_count_r <= fill_count_nxt;
    end
  end

  // tags and ages, no reset: only entries below the fill count are read
  always_ff @(posedge clk) begin
    if (touch && cap != '0) begin
      for (int i = 0; i < MAX_SHADOW_LINES; i++) begin
        if (repl_vec[i]) begin
          tag_r[i] <= line;
          age_r[i] <= '0;
        end else if (inc_vec[i]) begin
          age_r[i] <= age_r[i] + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: wait for the seen bit, then classify
  logic s1_v_r;
  logic s1_miss_r;
  logic s1_fill_r;
  logic s1_hit_r;
  logic s1_adv;
  logic out_cls_r;
  kind_t out_kind_r;
  kind_t kind;
  logic out_load;

  assign out_load  = !out_tvalid || out_tready;
  assign s1_adv    = s1_v_r && out_load;
  assign in_tready = !clr_active_r && (!s1_v_r || out_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_miss_r <= real_miss;
      s1_fill_r <= fills_line;
      s1_hit_r  <= touch && shadow_hit;
    end
  end

  // kind priority: cold, policy, conflict, capacity
  always_comb begin
    if (!s1_miss_r) begin
      kind = KIND_COLD;
    end else if (!seen_rdata) begin
      kind = KIND_COLD;
    end else if (!s1_fill_r) begin
      kind = KIND_POLICY;
    end else if (s1_hit_r) begin
      kind = KIND_CONFLICT;
    end else begin
      kind = KIND_CAPACITY;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (out_load) begin
      out_tvalid <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cls_r  <= s1_miss_r;
      out_kind_r <= kind;
    end
  end

  assign out_tdata = {(OUT_DATA_W-3)'(0), out_kind_r, out_cls_r};

  // ---------------------------------------------------------------------------
  // checks
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= cap)
    else $error("shadow fill count above active line count");

  a_tags_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("shadow cache holds a line twice");

  a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> fill_count_r == '0)
    else $error("register write did not empty the shadow cache");

  a_unclassified_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_cls_r |-> out_kind_r == KIND_COLD)
    else $error("kind set on an access that was not a real miss");

  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_v_r && !out_tvalid)
    else $error("beat in flight during bitmap clearing");

endmodule

FILE: sv/cmtc_ram.sv
// ----------------------------------------------------------------------------
// cmtc_ram
// Generic single-port synchronous RAM, registered read, read-first when
// a read and a write hit the same address in one cycle.
// ----------------------------------------------------------------------------
module cmtc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read old contents, then write
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
    end
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

FILE: bench/tb_cache_miss_three_c_classifier.sv
// ----------------------------------------------------------------------------
// tb_cache_miss_three_c_classifier
// Self-checking bench for the three-C miss classifier. Access beats go in
// over the input stream and each one is classified by a predictor kept in
// the bench: a seen bitmap plus a fully associative LRU shadow cache. Every
// result beat is compared with the oldest predicted verdict. Directed tests
// cover each miss kind, the reset value, the disabled shadow cache,
// saturation and reconfiguration. Random traffic then runs over several
// shadow sizes, first with both sides stalling and then with neither.
// ----------------------------------------------------------------------------
module tb_cache_miss_three_c_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import cmtc_pkg::*;

  localparam int MAX_LINES    = 64;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RAND_ITEMS   = 216;

  // one predicted result beat
  typedef struct packed {
    logic  classified;
    kind_t kind;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;

  // predictor state
  bit          seen_map [0:65535];
  logic [15:0] shadow_tag [0:MAX_LINES-1];
  logic [5:0]  shadow_rank [0:MAX_LINES-1];
  int          shadow_used;
  int          shadow_lines_cfg;

  verdict_t    miss_verdicts [$];
  int          error_count;
  int          cycle_count;
  int          accesses_sent;
  int          settings_used;
  int          hits_seen;
  int          kind_seen [0:3];
  int          send_idle_pct;
  int          recv_idle_pct;

  cache_miss_three_c_classifier dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, miss_verdicts.size());
      $display("simulation failed");
      $finish;
    end
  end

  // lru shadow cache lookup and update, returns 1 on a hit
  function automatic logic shadow_touch(input logic [15:0] addr);
    int       cap;
    int       victim;
    logic [5:0] old_rank;
    cap = (shadow_lines_cfg > MAX_LINES) ? MAX_LINES : shadow_lines_cfg;
    if (cap == 0) return 1'b0;
    for (int i = 0; i < shadow_used; i++) begin
      if (shadow_tag[i] == addr) begin
        old_rank = shadow_rank[i];
        for (int j = 0; j < shadow_used; j++)
          if (shadow_rank[j] < old_rank) shadow_rank[j]++;
        shadow_rank[i] = '0;
        return 1'b1;
      end
    end
    // free line left: age everything and append
    if (shadow_used < cap) begin
      for (int j = 0; j < shadow_used; j++) shadow_rank[j]++;
      shadow_tag[shadow_used]  = addr;
      shadow_rank[shadow_used] = '0;
      shadow_used++;
      return 1'b0;
    end
    // full: evict the oldest line
    victim = 0;
    for (int i = 1; i < shadow_used; i++)
      if (shadow_rank[i] > shadow_rank[victim]) victim = i;
    old_rank = shadow_rank[victim];
    for (int i = 0; i < shadow_used; i++)
      if (shadow_rank[i] < old_rank) shadow_rank[i]++;
    shadow_tag[victim]  = addr;
    shadow_rank[victim] = '0;
    return 1'b0;
  endfunction

  // verdict for one accepted access, updates the predictor state
  function automatic verdict_t classify_access(input logic [15:0] addr, input logic miss,
                                               input logic fill);
    verdict_t v;
    logic     first_touch;
    logic     hit;
    first_touch = !seen_map[addr];
    hit = fill ? shadow_touch(addr) : 1'b0;
    seen_map[addr] = 1'b1;
    v.classified = miss;
    if (!miss || first_touch) v.kind = KIND_COLD;
    else if (!fill) v.kind = KIND_POLICY;
    else if (hit) v.kind = KIND_CONFLICT;
    else v.kind = KIND_CAPACITY;
    return v;
  endfunction

  // send one access beat and record its verdict at acceptance
  task automatic send_access(input logic [15:0] addr, input logic miss, input logic fill);
    verdict_t v;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-18){1'b0}}, fill, miss, addr};
    do @(posedge clk); while (!in_tready);
    v = classify_access(addr, miss, fill);
    miss_verdicts = {miss_verdicts, v};
    accesses_sent++;
  endtask

  // drain, then write shadow_lines while the block is idle
  task automatic write_shadow_lines(input logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (miss_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_tready) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en        <= 1'b0;
    shadow_lines_cfg = int'(value);
    shadow_used      = 0;
    settings_used++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    verdict_t want;
    if (out_tvalid && out_tready) begin
      if (miss_verdicts.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, expected none actual 0x%0h", $realtime,
                 out_tdata);
      end else begin
        want = miss_verdicts.pop_front();
        if (out_tdata[0] !== want.classified) begin
          error_count++;
          $display("%0t: is_classified expected %0d actual %0d", $realtime,
                   want.classified, out_tdata[0]);
        end
        if (out_tdata[2:1] !== want.kind) begin
          error_count++;
          $display("%0t: miss_kind expected %0d actual %0d", $realtime, want.kind,
                   out_tdata[2:1]);
        end
        if (want.classified) kind_seen[want.kind]++;
        else hits_seen++;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // reset value of shadow_lines: 64 lines, so a repeat fill hits
  task automatic test_reset_default();
    send_access(16'h0001, 1'b1, 1'b1);
    send_access(16'h0001, 1'b1, 1'b1);
    send_access(16'h0001, 1'b0, 1'b0);
  endtask

  // every miss kind with a two-line shadow cache
  task automatic test_miss_kinds();
    write_shadow_lines(7'd2);
    send_access(16'h0000, 1'b0, 1'b1);
    send_access(16'hFFFF, 1'b1, 1'b1);
    send_access(16'h0000, 1'b1, 1'b1);
    send_access(16'h1234, 1'b1, 1'b0);
    send_access(16'h1234, 1'b1, 1'b0);
    send_access(16'h5555, 1'b1, 1'b1);
    send_access(16'hFFFF, 1'b1, 1'b1);
    send_access(16'hAAAA, 1'b0, 1'b0);
    send_access(16'hAAAA, 1'b1, 1'b1);
  endtask

  // zero lines: every lookup misses and nothing is kept
  task automatic test_disabled_shadow();
    write_shadow_lines(7'd0);
    send_access(16'h0001, 1'b1, 1'b1);
    send_access(16'h0001, 1'b1, 1'b1);
    send_access(16'h00FE, 1'b1, 1'b0);
  endtask

  // saturated size, then a rewrite that empties the shadow cache
  task automatic test_saturate_and_reconfig();
    write_shadow_lines(7'd127);
    send_access(16'h0F0F, 1'b1, 1'b1);
    send_access(16'h0F0F, 1'b1, 1'b1);
    send_access(16'hF0F0, 1'b0, 1'b1);
    write_shadow_lines(7'd2);
    send_access(16'h0F0F, 1'b1, 1'b1);
    send_access(16'h0F0F, 1'b1, 1'b1);
    send_access(16'hF0F0, 1'b1, 1'b1);
  endtask

  // random traffic over a small address pool sized around the shadow cache
  task automatic test_random_traffic(input logic [CFG_W-1:0] lines, input int n_items);
    logic [15:0] pool [0:127];
    int          pool_size;
    int          cap;
    int          base;
    logic        sweep;
    logic [15:0] addr;
    write_shadow_lines(lines);
    cap = (int'(lines) > MAX_LINES) ? MAX_LINES : int'(lines);
    pool_size = cap + 2 + $urandom_range(0, cap / 2 + 2);
    for (int i = 0; i < pool_size; i++) pool[i] = 16'($urandom);
    sweep = 1'b0;
    base  = 0;
    for (int k = 0; k < n_items; k++) begin
      // bursts of 16: either a cyclic sweep over the pool or random picks
      if (k % 16 == 0) begin
        sweep = ($urandom_range(2) == 0);
        base  = $urandom_range(pool_size - 1);
      end
      if ($urandom_range(9) == 0) addr = 16'($urandom);
      else if (sweep) addr = pool[(base + k) % pool_size];
      else addr = pool[$urandom_range(pool_size - 1)];
      send_access(addr, $urandom_range(3) != 0, $urandom_range(4) != 0);
    end
  endtask

  // test sequence
  initial begin
    logic [CFG_W-1:0] sizes [0:8];
    sizes = '{7'd1, 7'd4, 7'd64, 7'd127, 7'd0, 7'd2, 7'd8, 7'd65, 7'd33};
    shadow_lines_cfg = int'(SHADOW_LINES_RST);
    shadow_used      = 0;
    send_idle_pct    = 26;
    recv_idle_pct    = 86;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_default();
    test_miss_kinds();
    test_disabled_shadow();
    test_saturate_and_reconfig();
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 26;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      test_random_traffic(sizes[p], RAND_ITEMS);
    end

    // drain and let the pipeline settle
    in_tvalid <= 1'b0;
    while (miss_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d accesses over %0d shadow sizes; %0d not classified", accesses_sent,
             settings_used, hits_seen);
    $display("kinds checked: cold %0d policy %0d conflict %0d capacity %0d",
             kind_seen[KIND_COLD], kind_seen[KIND_POLICY], kind_seen[KIND_CONFLICT],
             kind_seen[KIND_CAPACITY]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
